/* hw/rtl/tcw_pkg.sv */
// tcw_pkg: shared constants and types of the text console character writer
// no dependencies; used by tcw_ctrl and text_console_char_writer_top
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 24;

  // stream field widths
  localparam int OP_W       = 1;
  localparam int CHAR_W     = 8;
  localparam int RD_ROW_W   = 5;
  localparam int RD_COL_W   = 7;
  localparam int CUR_COL_W  = 7;
  localparam int CUR_ROW_W  = 5;
  localparam int ATTR_W     = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 32;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
  localparam logic [OP_W-1:0] OP_READ = 1'b1;

  // control bytes
  localparam logic [CHAR_W-1:0] CHAR_BS = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_NL = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;

  localparam logic [CHAR_W-1:0] BLANK_CHAR  = 8'h20;
  localparam logic [ATTR_W-1:0] BLANK_ATTR  = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL  = {BLANK_ATTR, BLANK_CHAR};
  localparam logic [ATTR_W-1:0] COLOR_RESET = 8'h07;

  typedef struct packed {
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CHAR_W-1:0]    cell_char;
    logic [ATTR_W-1:0]    cell_attr;
    logic                 scrolled;
  } tcw_result_t;

endpackage

/* hw/rtl/tcw_cell_mem.sv */
// tcw_cell_mem: cell store, one write port and one registered read port
// depends on nothing but its parameters
`timescale 1ns / 1ps

module tcw_cell_mem #(
  parameter int DEPTH  = 1920,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/tcw_ctrl.sv */
// tcw_ctrl: sequencer for put and read beats, cursor, ring row offset and row clearing
// depends on tcw_pkg; drives the ports of tcw_cell_mem
`timescale 1ns / 1ps

module tcw_ctrl #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS,
  parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tcw_pkg::OP_W-1:0]      in_op,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char,
  input  logic [tcw_pkg::RD_ROW_W-1:0]  in_row,
  input  logic [tcw_pkg::RD_COL_W-1:0]  in_col,
  input  logic [tcw_pkg::ATTR_W-1:0]    color,
  output logic                          res_valid,
  input  logic                          res_ready,
  output tcw_pkg::tcw_result_t          res,
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_waddr,
  output logic [tcw_pkg::CELL_W-1:0]    mem_wdata,
  output logic [ADDR_W-1:0]             mem_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]    mem_rdata
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int DEPTH = COLUMNS * ROWS;

  typedef enum logic [2:0] {
    ST_CLEAR_ALL,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_BS_WR,
    ST_SCROLL,
    ST_RESULT
  } state_t;

  state_t state;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  line;
  logic [ROW_W-1:0]  top;
  logic [ADDR_W-1:0] top_base;
  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] sweep_end;
  logic [ADDR_W-1:0] addr_hold;

  // latched beat
  logic [tcw_pkg::OP_W-1:0]     op_q;
  logic [tcw_pkg::CHAR_W-1:0]   ch_q;
  logic [tcw_pkg::RD_ROW_W-1:0] rr_q;
  logic [tcw_pkg::RD_COL_W-1:0] rc_q;

  logic [tcw_pkg::CHAR_W-1:0] res_char;
  logic [tcw_pkg::ATTR_W-1:0] res_attr;
  logic                       res_scr;

  logic              is_read;
  logic              is_ctrl;
  logic              rd_ok;
  logic [ROW_W-1:0]  a_row;
  logic [ADDR_W-1:0] a_col;
  logic [ROW_W:0]    phys_sum;
  logic [ROW_W-1:0]  phys_row;
  logic [ADDR_W-1:0] addr_c;
  logic [COL_W:0]    ncol;
  logic [ROW_W:0]    nline;
  logic              do_scroll;

  always_comb begin
    is_read = (op_q == tcw_pkg::OP_READ);
    is_ctrl = ch_q inside {tcw_pkg::CHAR_NL, tcw_pkg::CHAR_BS, tcw_pkg::CHAR_CR};
    rd_ok   = (32'(rr_q) < 32'(ROWS)) && (32'(rc_q) < 32'(COLUMNS));

    // logical cell to address
    if (is_read) begin
      a_row = ROW_W'(rr_q);
      a_col = ADDR_W'(rc_q);
    end else if (ch_q == tcw_pkg::CHAR_BS) begin
      a_row = line;
      a_col = ADDR_W'(col) - ADDR_W'(1);
    end else begin
      a_row = line;
      a_col = ADDR_W'(col);
    end
    // ring row offset: physical row = logical row + top, modulo ROWS
    phys_sum = (ROW_W+1)'(a_row) + (ROW_W+1)'(top);
    if (32'(phys_sum) >= 32'(ROWS)) begin
      phys_sum = phys_sum - (ROW_W+1)'(ROWS);
    end
    phys_row = phys_sum[ROW_W-1:0];
    addr_c   = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + a_col;

    // cursor after a put other than backspace
    case (ch_q)
      tcw_pkg::CHAR_NL: begin
        ncol  = '0;
        nline = (ROW_W+1)'(line) + (ROW_W+1)'(1);
      end
      tcw_pkg::CHAR_CR: begin
        ncol  = '0;
        nline = (ROW_W+1)'(line);
      end
      default: begin
        ncol  = (COL_W+1)'(col) + (COL_W+1)'(1);
        nline = (ROW_W+1)'(line);
      end
    endcase
    if (32'(ncol) >= 32'(COLUMNS)) begin
      ncol  = '0;
      nline = nline + (ROW_W+1)'(1);
    end
    do_scroll = (32'(nline) >= 32'(ROWS));
  end

  // single write port: sweeps, printable store, backspace write-back
  always_comb begin
    mem_raddr = addr_c;
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = tcw_pkg::BLANK_CELL;
    case (state)
      ST_CLEAR_ALL, ST_SCROLL: begin
        mem_we = 1'b1;
      end
      ST_EXEC: begin
        mem_we    = !is_read && !is_ctrl;
        mem_waddr = addr_c;
        mem_wdata = {color, ch_q};
      end
      ST_BS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_hold;
        mem_wdata = {mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], tcw_pkg::BLANK_CHAR};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_RESULT);

  always_comb begin
    res.cursor_col = tcw_pkg::CUR_COL_W'(col);
    res.cursor_row = tcw_pkg::CUR_ROW_W'(line);
    res.cell_char  = res_char;
    res.cell_attr  = res_attr;
    res.scrolled   = res_scr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR_ALL;
      col        <= '0;
      line       <= '0;
      top        <= '0;
      top_base   <= '0;
      sweep_addr <= '0;
      sweep_end  <= ADDR_W'(DEPTH - 1);
    end else begin
      case (state)
        ST_CLEAR_ALL: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (sweep_addr == sweep_end) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            op_q  <= in_op;
            ch_q  <= in_char;
            rr_q  <= in_row;
            rc_q  <= in_col;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_char <= '0;
          res_attr <= '0;
          res_scr  <= 1'b0;
          if (is_read) begin
            state <= rd_ok ? ST_RD_WAIT : ST_RESULT;
          end else if (ch_q == tcw_pkg::CHAR_BS) begin
            if (col != '0) begin
              col       <= col - COL_W'(1);
              addr_hold <= addr_c;
              state     <= ST_BS_WR;
            end else begin
              state <= ST_RESULT;
            end
          end else begin
            col <= COL_W'(ncol);
            if (do_scroll) begin
              // old top row becomes the new last row and is blanked
              line       <= ROW_W'(ROWS - 1);
              res_scr    <= 1'b1;
              sweep_addr <= top_base;
              sweep_end  <= top_base + ADDR_W'(COLUMNS - 1);
              if (32'(top) == ROWS - 1) begin
                top      <= '0;
                top_base <= '0;
              end else begin
                top      <= top + ROW_W'(1);
                top_base <= top_base + ADDR_W'(COLUMNS);
              end
              state <= ST_SCROLL;
            end else begin
              line  <= ROW_W'(nline);
              state <= ST_RESULT;
            end
          end
        end
        ST_RD_WAIT: begin
          res_char <= mem_rdata[tcw_pkg::CHAR_W-1:0];
          res_attr <= mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
          state    <= ST_RESULT;
        end
        ST_BS_WR: begin
          state <= ST_RESULT;
        end
        ST_SCROLL: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (sweep_addr == sweep_end) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR_ALL;
        end
      endcase
    end
  end

  // ring base must track the row offset
  a_top_base: assert property (@(posedge clk) disable iff (rst)
    32'(top_base) == 32'(top) * COLUMNS)
    else $error("top_base out of step with top");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(line) < ROWS) && (32'(col) < COLUMNS))
    else $error("cursor outside grid");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL || state == ST_CLEAR_ALL) |-> sweep_addr <= sweep_end)
    else $error("row clear ran past its end");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.scrolled) |-> (32'(line) == ROWS - 1))
    else $error("scrolled result with cursor off the last row");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_RESULT || state == ST_RD_WAIT) |-> !mem_we)
    else $error("store written outside a write step");

endmodule

/* hw/rtl/text_console_char_writer_top.sv */
// text_console_char_writer_top: stream wrapper, color register and output register
// depends on tcw_pkg, tcw_cell_mem and tcw_ctrl
`timescale 1ns / 1ps

// Text console over a ROWS x COLUMNS grid of 16-bit cells (attribute in the high
// byte, character in the low byte) held in one single-port-write memory with a
// registered read. After reset the grid is cleared to space/0x07 one cell a cycle,
// with s_axis_tready low. Then one beat is handled at a time: carriage return,
// newline and printable bytes go from the execute step straight to the result,
// a read inside the grid or a backspace that moves the cursor adds one memory
// step (one memory read, then output or write-back), a read outside the grid or
// a backspace at column 0 goes straight to the result, and a put that scrolls
// adds a clear of the COLUMNS cells of one row, since scrolling only moves a ring
// row offset and the single write port then blanks the new last row. A finished
// result sits in the output register, so the next beat is taken while it waits.
// cfg_we writes the text color used for printable bytes; write it only while idle.
module text_console_char_writer_top #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // character[7:0], read_row[12:8], read_col[19:13], zero fill
  input  logic [tcw_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // operation[0]
  input  logic [tcw_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cursor_col[6:0], cursor_row[11:7], cell_char[19:12], cell_attr[27:20],
  // scrolled[28], zero fill
  output logic [tcw_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wdata
);

  localparam int DEPTH  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [tcw_pkg::ATTR_W-1:0] text_color;
  logic                       res_valid;
  logic                       res_ready;
  tcw_pkg::tcw_result_t       res;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tcw_pkg::COLOR_RESET;
    end else if (cfg_we) begin
      text_color <= cfg_wdata;
    end
  end

  tcw_cell_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (tcw_pkg::CELL_W),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_char   (s_axis_tdata[7:0]),
    .in_row    (s_axis_tdata[12:8]),
    .in_col    (s_axis_tdata[19:13]),
    .color     (text_color),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register frees the sequencer as soon as a result is loaded
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {3'b000, res.scrolled, res.cell_attr, res.cell_char,
                       res.cursor_row, res.cursor_col};
    end
  end

endmodule
